### rtl/core/bpp_pkg.sv
// Shared types and constants of the band peak picker.
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

    localparam int NUM_BANDS       = 6;
    localparam int BAND_IDX_W      = $clog2(NUM_BANDS);
    localparam int MAG_BITS        = 32;
    localparam int IN_MAG_W        = 32;
    localparam int OUT_MAG_W       = 32;
    localparam int REAL_W          = 32;
    localparam int BIN_CNT_W       = 10;
    localparam int BIN_W           = 9;
    localparam int FRAME_W         = 32;
    localparam int DUR_W           = 24;
    localparam int TIME_W          = 56;
    localparam int FRAME_BINS_LOG2 = 10;
    localparam int FRAME_BINS      = 1 << FRAME_BINS_LOG2;
    localparam int SUM_W           = MAG_BITS + 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [BIN_CNT_W-1:0] BIN_SAT   = {BIN_CNT_W{1'b1}};
    localparam logic [DUR_W-1:0]     DUR_RESET = DUR_W'(23219);

    // Half-open band limits, band 0 in the lowest slot.
    localparam logic [NUM_BANDS-1:0][BIN_CNT_W-1:0] BAND_LO = {
        BIN_CNT_W'(160), BIN_CNT_W'(80), BIN_CNT_W'(40),
        BIN_CNT_W'(20),  BIN_CNT_W'(10), BIN_CNT_W'(0)
    };
    localparam logic [NUM_BANDS-1:0][BIN_CNT_W-1:0] BAND_HI = {
        BIN_CNT_W'(511), BIN_CNT_W'(160), BIN_CNT_W'(80),
        BIN_CNT_W'(40),  BIN_CNT_W'(20),  BIN_CNT_W'(10)
    };

    // Everything the back end needs to pick the peaks of one finished frame.
    typedef struct packed {
        logic [NUM_BANDS-1:0]                seen;
        logic [NUM_BANDS-1:0][MAG_BITS-1:0]  mag;
        logic [NUM_BANDS-1:0][BIN_W-1:0]     bin;
        logic [NUM_BANDS-1:0][REAL_W-1:0]    rval;
        logic [FRAME_W-1:0]                  frame;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

endpackage

`default_nettype wire

### rtl/core/bpp_front.sv
// Front end: takes bin words, tracks the per-band maxima and hands over finished frames.
`timescale 1ns / 1ps
`default_nettype none

module bpp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bpp_pkg::IN_MAG_W-1:0]  i_bin_magnitude,
    input  wire logic signed [bpp_pkg::REAL_W-1:0] i_bin_real,
    input  wire logic                          i_frame_end,
    input  wire bpp_pkg::t_q_status            i_q_status,
    output logic                               o_push,
    output bpp_pkg::t_frame_rec                o_rec
);

    logic [bpp_pkg::NUM_BANDS-1:0]                       r_seen, n_seen;
    logic [bpp_pkg::NUM_BANDS-1:0][bpp_pkg::MAG_BITS-1:0] r_mag, n_mag;
    logic [bpp_pkg::NUM_BANDS-1:0][bpp_pkg::BIN_W-1:0]    r_bin, n_bin;
    logic [bpp_pkg::NUM_BANDS-1:0][bpp_pkg::REAL_W-1:0]   r_rval, n_rval;
    logic [bpp_pkg::BIN_CNT_W-1:0]                       r_bin_cnt;
    logic [bpp_pkg::FRAME_W-1:0]                         r_frame;
    logic [bpp_pkg::MAG_BITS-1:0]                        mag_in;
    logic                                                accept;

    // The queue must have room for the frame record before any bin is taken.
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign mag_in     = bpp_pkg::MAG_BITS'(i_bin_magnitude);

    always_comb begin
        n_seen = r_seen;
        n_mag  = r_mag;
        n_bin  = r_bin;
        n_rval = r_rval;
        for (int b = 0; b < bpp_pkg::NUM_BANDS; b++) begin
            if (r_bin_cnt >= bpp_pkg::BAND_LO[b] && r_bin_cnt < bpp_pkg::BAND_HI[b] &&
                (!r_seen[b] || mag_in > r_mag[b])) begin
                n_seen[b] = 1'b1;
                n_mag[b]  = mag_in;
                n_bin[b]  = r_bin_cnt[bpp_pkg::BIN_W-1:0];
                n_rval[b] = i_bin_real;
            end
        end
    end

    // The record carries the maxima including the marked bin itself.
    assign o_push       = accept && i_frame_end;
    assign o_rec.seen   = n_seen;
    assign o_rec.mag    = n_mag;
    assign o_rec.bin    = n_bin;
    assign o_rec.rval   = n_rval;
    assign o_rec.frame  = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_bin_cnt <= '0;
            r_frame   <= '0;
        end else if (accept) begin
            if (i_frame_end) begin
                r_seen    <= '0;
                r_bin_cnt <= '0;
                r_frame   <= r_frame + bpp_pkg::FRAME_W'(1);
            end else begin
                r_seen <= n_seen;
                if (r_bin_cnt != bpp_pkg::BIN_SAT) begin
                    r_bin_cnt <= r_bin_cnt + bpp_pkg::BIN_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag  <= n_mag;
            r_bin  <= n_bin;
            r_rval <= n_rval;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bpp_queue.sv
// Short queue of finished frame records between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module bpp_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire bpp_pkg::t_frame_rec  i_rec,
    input  wire logic                 i_pop,
    output bpp_pkg::t_frame_rec       o_head,
    output bpp_pkg::t_q_status        o_status
);

    bpp_pkg::t_frame_rec             r_mem [bpp_pkg::QUEUE_DEPTH];
    logic [bpp_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [bpp_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [bpp_pkg::QUEUE_AW:0]      r_count;

    assign o_head            = r_mem[r_rd_ptr];
    assign o_status.full     = (r_count == (bpp_pkg::QUEUE_AW + 1)'(bpp_pkg::QUEUE_DEPTH));
    assign o_status.nonempty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bpp_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + bpp_pkg::QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (bpp_pkg::QUEUE_AW + 1)'(1);
                2'b01:   r_count <= r_count - (bpp_pkg::QUEUE_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/bpp_back.sv
// Back end: averages the band maxima of a frame and emits the peak words.
`timescale 1ns / 1ps
`default_nettype none

module bpp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bpp_pkg::t_frame_rec           i_head,
    input  wire bpp_pkg::t_q_status            i_q_status,
    output logic                               o_pop,
    input  wire logic [bpp_pkg::DUR_W-1:0]     i_frame_dur,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [bpp_pkg::BIN_W-1:0]          o_peak_bin,
    output logic signed [bpp_pkg::REAL_W-1:0]  o_peak_real,
    output logic [bpp_pkg::OUT_MAG_W-1:0]      o_peak_magnitude,
    output logic [bpp_pkg::FRAME_W-1:0]        o_frame_number,
    output logic [bpp_pkg::TIME_W-1:0]         o_peak_time_us,
    output logic                               o_last_peak
);

    localparam int BASE_W = bpp_pkg::FRAME_W + bpp_pkg::DUR_W;
    localparam int PROD_W = bpp_pkg::BIN_W + bpp_pkg::DUR_W;
    localparam int FRAC_W = PROD_W - bpp_pkg::FRAME_BINS_LOG2;
    localparam logic [bpp_pkg::BAND_IDX_W-1:0] LAST_BAND =
        bpp_pkg::BAND_IDX_W'(bpp_pkg::NUM_BANDS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_MARK = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_back_state;

    t_back_state                       r_state, n_state;
    logic [bpp_pkg::BAND_IDX_W-1:0]    r_idx, n_idx;
    logic [bpp_pkg::SUM_W-1:0]         r_sum, n_sum;
    logic [bpp_pkg::NUM_BANDS-1:0]     r_mask, n_mask;
    logic [bpp_pkg::TIME_W-1:0]        r_base;
    logic [FRAC_W-1:0]                 r_frac;
    logic [BASE_W-1:0]                 base_prod;
    logic [PROD_W-1:0]                 frac_prod;
    logic [bpp_pkg::NUM_BANDS-1:0]     qual;
    logic [bpp_pkg::NUM_BANDS-1:0]     above;
    logic [bpp_pkg::SUM_W-1:0]         mag_ext;
    logic                              out_free;
    logic                              load;
    logic                              is_last;

    assign base_prod = BASE_W'(i_head.frame) * BASE_W'(i_frame_dur);
    assign frac_prod = PROD_W'(i_head.bin[r_idx]) * PROD_W'(i_frame_dur);
    assign out_free  = !o_out_valid || !i_out_stall;

    // A seen band qualifies when six times its maximum reaches the sum of the maxima of all seen bands.
    always_comb begin
        qual    = '0;
        mag_ext = '0;
        for (int b = 0; b < bpp_pkg::NUM_BANDS; b++) begin
            mag_ext = bpp_pkg::SUM_W'(i_head.mag[b]);
            qual[b] = i_head.seen[b] && (((mag_ext << 2) + (mag_ext << 1)) >= r_sum);
        end
    end

    always_comb begin
        for (int b = 0; b < bpp_pkg::NUM_BANDS; b++) begin
            above[b] = (bpp_pkg::BAND_IDX_W'(b) > r_idx);
        end
    end

    assign is_last = ~|(r_mask & above);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_mask  = r_mask;
        o_pop   = 1'b0;
        load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_status.nonempty) begin
                    n_state = S_SUM;
                    n_idx   = '0;
                    n_sum   = '0;
                end
            end
            S_SUM: begin
                if (i_head.seen[r_idx]) begin
                    n_sum = r_sum + bpp_pkg::SUM_W'(i_head.mag[r_idx]);
                end
                if (r_idx == LAST_BAND) begin
                    n_state = S_MARK;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + bpp_pkg::BAND_IDX_W'(1);
                end
            end
            S_MARK: begin
                n_mask  = qual;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_mask[r_idx]) begin
                    n_state = S_OUT;
                end else if (r_idx == LAST_BAND) begin
                    o_pop   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + bpp_pkg::BAND_IDX_W'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    load = 1'b1;
                    if (is_last) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + bpp_pkg::BAND_IDX_W'(1);
                        n_state = S_MUL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_mask <= n_mask;
        if (r_state == S_SUM) begin
            r_base <= bpp_pkg::TIME_W'(base_prod);
        end
        if (r_state == S_MUL) begin
            r_frac <= frac_prod[PROD_W-1:bpp_pkg::FRAME_BINS_LOG2];
        end
        if (load) begin
            o_peak_bin       <= i_head.bin[r_idx];
            o_peak_real      <= i_head.rval[r_idx];
            o_peak_magnitude <= bpp_pkg::OUT_MAG_W'(i_head.mag[r_idx]);
            o_frame_number   <= i_head.frame;
            o_peak_time_us   <= r_base + bpp_pkg::TIME_W'(r_frac);
            o_last_peak      <= is_last;
        end
    end

endmodule

`default_nettype wire

### rtl/core/band_peak_picker.sv
// Top level of the band peak picker: duration register, front end, frame queue, back end.
// Input: one bin word per cycle; the input stalls only while two finished frames wait.
// With the back end idle, a frame's end-marked bin is pushed into the queue, and the back end then
// passes its idle, summing, marking, multiply and output states before the first peak word is shown;
// each earlier band that is not a peak adds a multiply step. The back end handles one queued frame
// at a time: it sums, marks, then multiplies and emits per band; output stalls hold it.
// Reset is synchronous: counters, queue and output valid clear, the duration returns to 23219.
`timescale 1ns / 1ps
`default_nettype none

module band_peak_picker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bpp_pkg::DUR_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [bpp_pkg::IN_MAG_W-1:0]      i_bin_magnitude,
    input  wire logic signed [bpp_pkg::REAL_W-1:0] i_bin_real,
    input  wire logic                              i_frame_end,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [bpp_pkg::BIN_W-1:0]              o_peak_bin,
    output logic signed [bpp_pkg::REAL_W-1:0]      o_peak_real,
    output logic [bpp_pkg::OUT_MAG_W-1:0]          o_peak_magnitude,
    output logic [bpp_pkg::FRAME_W-1:0]            o_frame_number,
    output logic [bpp_pkg::TIME_W-1:0]             o_peak_time_us,
    output logic                                   o_last_peak
);

    logic [bpp_pkg::DUR_W-1:0] r_frame_dur;
    bpp_pkg::t_frame_rec       push_rec;
    bpp_pkg::t_frame_rec       head_rec;
    bpp_pkg::t_q_status        q_status;
    logic                      push;
    logic                      pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_dur <= bpp_pkg::DUR_RESET;
        end else if (i_cfg_we) begin
            r_frame_dur <= i_cfg_wdata;
        end
    end

    bpp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_bin_magnitude (i_bin_magnitude),
        .i_bin_real      (i_bin_real),
        .i_frame_end     (i_frame_end),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_rec           (push_rec)
    );

    bpp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_head   (head_rec),
        .o_status (q_status)
    );

    bpp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_rec),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .i_frame_dur      (r_frame_dur),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_peak_bin       (o_peak_bin),
        .o_peak_real      (o_peak_real),
        .o_peak_magnitude (o_peak_magnitude),
        .o_frame_number   (o_frame_number),
        .o_peak_time_us   (o_peak_time_us),
        .o_last_peak      (o_last_peak)
    );

endmodule

`default_nettype wire

### rtl/core/bpp_checker.sv
// Port-level checks of the band peak picker and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bpp_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_in_stall,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic [bpp_pkg::BIN_W-1:0]         o_peak_bin,
    input  wire logic signed [bpp_pkg::REAL_W-1:0] o_peak_real,
    input  wire logic [bpp_pkg::OUT_MAG_W-1:0]     o_peak_magnitude,
    input  wire logic [bpp_pkg::FRAME_W-1:0]       o_frame_number,
    input  wire logic [bpp_pkg::TIME_W-1:0]        o_peak_time_us,
    input  wire logic                              o_last_peak
);

    // A stalled peak word holds still until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_peak_bin) &&
        $stable(o_peak_real) && $stable(o_peak_magnitude) &&
        $stable(o_peak_time_us) && $stable(o_frame_number) && $stable(o_last_peak))
        else $error("peak word changed while stalled");

    // Reset leaves no peak word pending and an empty frame queue.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("peak word valid straight after reset");

    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled straight after reset");

    // Only bins inside a band can be reported, and the last band ends below 511.
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_peak_bin < bpp_pkg::BIN_W'(511))
        else $error("peak bin outside every band");

endmodule

bind band_peak_picker bpp_checker u_bpp_checker (.*);

`default_nettype wire
